@@ sv/ucn_pkg.sv @@
// ----------------------------------------------------------------------------
// ucn_pkg
// Shared types, constants and lookup functions of the UTF-8 confusable
// normalizer.
// ----------------------------------------------------------------------------
package ucn_pkg;

    localparam int WIN_DEPTH = 4;
    localparam int CNT_W     = $clog2(WIN_DEPTH + 1);

    localparam logic [6:0] CHAR_SPACE = 7'h20;
    localparam logic [6:0] CHAR_NUL   = 7'h00;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_SPACE,
        ACT_CHAR
    } act_t;

    // Decoded unit at the head of the window
    typedef struct packed {
        logic [CNT_W-1:0] len;
        act_t             act;
        logic [6:0]       ch;
    } unit_dec_t;

    // Window control -> output stage
    typedef struct packed {
        logic       push;
        logic [6:0] ch;
        logic       spill;   // send the held character on, not last
        logic       finish;
    } out_ctl_t;

    // Output stage -> window control
    typedef struct packed {
        logic held;
        logic push_ok;
        logic finish_ok;
    } out_sts_t;

    function automatic logic [6:0] to_lower7(input logic [6:0] c);
        logic [6:0] r;
        r = c;
        if (c >= 7'h41 && c <= 7'h5A) begin
            r = c + 7'h20;
        end
        return r;
    endfunction

    // Zero-width, bidi and BOM three-byte sequences
    function automatic logic is_hidden3(input logic [7:0] b0, input logic [7:0] b1,
                                        input logic [7:0] b2);
        logic hit;
        hit = 1'b0;
        if (b0 == 8'hE2 && b1 == 8'h80) begin
            hit = (b2 inside {8'h8B, 8'h8C, 8'h8D, [8'hAA:8'hAE]});
        end else if (b0 == 8'hE2 && b1 == 8'h81) begin
            hit = (b2 inside {8'hA0, [8'hA2:8'hA4]});
        end else if (b0 == 8'hEF && b1 == 8'hBB) begin
            hit = (b2 == 8'hBF);
        end
        return hit;
    endfunction

    // Cyrillic / Greek homoglyphs; bit 7 flags a hit
    function automatic logic [7:0] glyph_lookup(input logic [7:0] b0, input logic [7:0] b1);
        logic [7:0] r;
        case ({b0, b1})
            16'hD0B0: r = 8'h80 | 8'h61;  // a
            16'hD0B5: r = 8'h80 | 8'h65;  // e
            16'hD0BE: r = 8'h80 | 8'h6F;  // o
            16'hD180: r = 8'h80 | 8'h70;  // p
            16'hD181: r = 8'h80 | 8'h63;  // c
            16'hD185: r = 8'h80 | 8'h78;  // x
            16'hD183: r = 8'h80 | 8'h79;  // y
            16'hD196: r = 8'h80 | 8'h69;  // i
            16'hD195: r = 8'h80 | 8'h73;  // s
            16'hCEB1: r = 8'h80 | 8'h61;  // a
            16'hCEB5: r = 8'h80 | 8'h65;  // e
            16'hCEB9: r = 8'h80 | 8'h69;  // i
            16'hCEBA: r = 8'h80 | 8'h6B;  // k
            16'hCEBD: r = 8'h80 | 8'h6E;  // n
            16'hCEBF: r = 8'h80 | 8'h6F;  // o
            16'hCF81: r = 8'h80 | 8'h70;  // p
            16'hCF84: r = 8'h80 | 8'h74;  // t
            default:  r = 8'h00;
        endcase
        return r;
    endfunction

    // Latin-1 letter base for C3 xx, indexed by xx & 0x3F; bit 7 flags a letter
    function automatic logic [7:0] accent_lookup(input logic [5:0] idx);
        logic [7:0] r;
        case (idx[4:0]) inside
            [5'd0:5'd5]:   r = 8'h80 | 8'h61;  // a
            5'd7:          r = 8'h80 | 8'h63;  // c
            [5'd8:5'd11]:  r = 8'h80 | 8'h65;  // e
            [5'd12:5'd15]: r = 8'h80 | 8'h69;  // i
            5'd16:         r = 8'h80 | 8'h64;  // d
            5'd17:         r = 8'h80 | 8'h6E;  // n
            [5'd18:5'd22],
            5'd24:         r = 8'h80 | 8'h6F;  // o
            [5'd25:5'd28]: r = 8'h80 | 8'h75;  // u
            5'd29:         r = 8'h80 | 8'h79;  // y
            5'd31:         r = idx[5] ? (8'h80 | 8'h79) : (8'h80 | 8'h73);  // y / sharp s
            default:       r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

@@ sv/ucn_decode.sv @@
// ----------------------------------------------------------------------------
// ucn_decode
// Classifies the code unit at the head of the lookahead window: how many
// bytes it spans and whether it yields nothing, whitespace or a character.
// ----------------------------------------------------------------------------
module ucn_decode
    import ucn_pkg::*;
(
    input  logic [7:0]       win0,
    input  logic [7:0]       win1,
    input  logic [7:0]       win2,
    input  logic [CNT_W-1:0] avail,
    output unit_dec_t        dec
);

    logic       has2;
    logic       has3;
    logic       has4;
    logic       cont1;
    logic [7:0] glyph;
    logic [7:0] accent;
    logic       fw_ok;
    logic [6:0] fw_ch;

    assign has2  = (avail >= CNT_W'(2));
    assign has3  = (avail >= CNT_W'(3));
    assign has4  = (avail >= CNT_W'(4));
    assign cont1 = (win1[7:6] == 2'b10);
    assign glyph  = glyph_lookup(win0, win1);
    assign accent = accent_lookup(win1[5:0]);

    // Fullwidth U+FF01..U+FF5E: EF BC xx / EF BD xx
    assign fw_ch = 7'h20 + {win1[0], win2[5:0]};
    assign fw_ok = (win1 == 8'hBC) ? (win2[5:0] != 6'h00) :
                   (win1 == 8'hBD) ? (win2[5:0] <= 6'h1E) : 1'b0;

    // the fourth byte only counts through the length of a four-byte unit
    always_comb begin
        dec.len = CNT_W'(1);
        dec.act = ACT_NONE;
        dec.ch  = CHAR_NUL;
        if (has3 && is_hidden3(win0, win1, win2)) begin
            dec.len = CNT_W'(3);
        end else if (has2 && win0 == 8'hC2 && win1 == 8'hAD) begin
            dec.len = CNT_W'(2);
        end else if (has3 && win0 == 8'hE2 && win1 == 8'h80
                     && (win2 == 8'hA8 || win2 == 8'hA9)) begin
            dec.len = CNT_W'(3);
            dec.act = ACT_SPACE;
        end else if (has2 && glyph[7]) begin
            dec.len = CNT_W'(2);
            dec.act = ACT_CHAR;
            dec.ch  = glyph[6:0];
        end else if (win0[7]) begin
            if (win0[7:3] == 5'b11110 && has4 && cont1) begin
                dec.len = CNT_W'(4);
            end else if (win0[7:4] == 4'b1110 && has3 && cont1) begin
                dec.len = CNT_W'(3);
                if (win0 == 8'hEF && fw_ok) begin
                    dec.act = ACT_CHAR;
                    dec.ch  = to_lower7(fw_ch);
                end
            end else if (win0[7:5] == 3'b110 && has2 && cont1) begin
                dec.len = CNT_W'(2);
                if (win0 == 8'hC3 && accent[7]) begin
                    dec.act = ACT_CHAR;
                    dec.ch  = accent[6:0];
                end
            end
        end else if (win0 == 8'h20 || (win0 >= 8'h09 && win0 <= 8'h0D)) begin
            dec.act = ACT_SPACE;
        end else begin
            dec.act = ACT_CHAR;
            dec.ch  = to_lower7(win0[6:0]);
        end
    end

endmodule

@@ sv/ucn_out_stage.sv @@
// ----------------------------------------------------------------------------
// ucn_out_stage
// Holds the newest character back by one so the final one of a string can be
// tagged last, and drives the registered master-side stream.
// ----------------------------------------------------------------------------
module ucn_out_stage
    import ucn_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  out_ctl_t   ctl,
    output out_sts_t   sts,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [6:0] out_char, [7] zero
    output logic [0:0] m_tuser,   // [0] has_char
    output logic       m_tlast    // out_last
);

    logic       held_valid_reg, held_valid_next;
    logic [6:0] held_char_reg,  held_char_next;
    logic       out_valid_reg,  out_valid_next;
    logic [6:0] out_char_reg,   out_char_next;
    logic       out_has_reg,    out_has_next;
    logic       out_last_reg,   out_last_next;
    logic       out_free;
    logic       load_out;

    assign out_free = !out_valid_reg || m_tready;
    assign load_out = (ctl.push && held_valid_reg) || ctl.spill || ctl.finish;

    assign sts.held      = held_valid_reg;
    assign sts.push_ok   = !held_valid_reg || out_free;
    assign sts.finish_ok = out_free;

    always_comb begin
        held_valid_next = held_valid_reg;
        held_char_next  = held_char_reg;
        out_char_next   = out_char_reg;
        out_has_next    = out_has_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        if (load_out) begin
            out_valid_next = 1'b1;
        end
        if (ctl.push) begin
            held_valid_next = 1'b1;
            held_char_next  = ctl.ch;
            // a waiting output stays untouched when nothing is held yet
            if (held_valid_reg) begin
                out_char_next = held_char_reg;
                out_has_next  = 1'b1;
                out_last_next = 1'b0;
            end
        end else if (ctl.spill) begin
            held_valid_next = 1'b0;
            out_char_next   = held_char_reg;
            out_has_next    = 1'b1;
            out_last_next   = 1'b0;
        end else if (ctl.finish) begin
            held_valid_next = 1'b0;
            out_char_next   = held_valid_reg ? held_char_reg : CHAR_NUL;
            out_has_next    = held_valid_reg;
            out_last_next   = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            held_valid_reg <= held_valid_next;
            out_valid_reg  <= out_valid_next;
        end
        held_char_reg <= held_char_next;
        out_char_reg  <= out_char_next;
        out_has_reg   <= out_has_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {1'b0, out_char_reg};
    assign m_tuser[0] = out_has_reg;
    assign m_tlast    = out_last_reg;

    a_bare_marker_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tlast && m_tdata == 8'h00))
        else $error("bare end marker without last flag or with data");

    a_finish_empties_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.finish |=> !held_valid_reg)
        else $error("held character survived end of string");

    a_stall_keeps_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                     && $stable(m_tlast)))
        else $error("output transaction changed while stalled");

endmodule

@@ sv/utf8_confusable_normalizer_unit.sv @@
// ----------------------------------------------------------------------------
// utf8_confusable_normalizer_unit
// UTF-8 in, lowercased ASCII out, with confusable and invisible characters
// folded away and whitespace collapsed.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one UTF-8 byte per transaction, tlast on the final
//   byte of a string. m_ channel carries one output character per
//   transaction (tuser[0] = has_char), tlast on the final one of a string;
//   when the drain after the final byte yields no character, the string
//   closes with one transaction with has_char 0.
//   A four-byte window is decoded in one pass per cycle; a byte is decoded
//   once three more bytes of its string follow it, or at end of string.
//   The newest character is held back one slot to tag the last one, so a
//   character reaches the registered output once the next character (or
//   the string end) arrives.
//   Throughput: one byte per cycle while the output keeps up. An emitted
//   collapsed space stalls the window while it takes its output slot. After
//   tlast, the input stalls while the window drains, one unit per cycle (up
//   to four) while the output keeps up, then the end goes out; if the drain
//   yields no character while an earlier one is still held, that one goes
//   out first and the end follows it separately. Reset clears the window
//   and all string state. When m_tready is low, bytes are still taken until
//   the window is full and its head unit needs an output slot.
// ----------------------------------------------------------------------------
module utf8_confusable_normalizer_unit
    import ucn_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // in_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [6:0] out_char, [7] zero
    output logic [0:0] m_tuser,   // [0] has_char
    output logic       m_tlast    // out_last
);

    logic [7:0]       win_reg [WIN_DEPTH];
    logic [7:0]       win_next [WIN_DEPTH];
    logic [CNT_W-1:0] count_reg, count_next;
    logic             flush_reg, flush_next;
    logic             space_pending_reg, space_pending_next;
    logic             drain_char_reg, drain_char_next;

    unit_dec_t        dec;
    out_ctl_t         ctl;
    out_sts_t         sts;

    logic             step_req;
    logic             is_char;
    logic             space_first;
    logic             step_go;
    logic             consume;
    logic             accept;
    logic             at_end;
    logic [CNT_W-1:0] count_sh;

    ucn_decode u_decode (
        .win0  (win_reg[0]),
        .win1  (win_reg[1]),
        .win2  (win_reg[2]),
        .avail (count_reg),
        .dec   (dec)
    );

    ucn_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (ctl),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    assign step_req    = flush_reg ? (count_reg != '0) : (count_reg == CNT_W'(WIN_DEPTH));
    assign is_char     = (dec.act == ACT_CHAR);
    // pending space goes out first; the unit stays in the window and is decoded again
    assign space_first = is_char && space_pending_reg;
    assign step_go     = step_req && (!is_char || sts.push_ok);
    assign consume     = step_go && !space_first;

    // a held character from before the final byte is not the last result
    // unless the drain itself produced it
    assign at_end     = flush_reg && (count_reg == '0) && sts.finish_ok;
    assign ctl.push   = step_go && is_char;
    assign ctl.ch     = space_first ? CHAR_SPACE : dec.ch;
    assign ctl.spill  = at_end && sts.held && !drain_char_reg;
    assign ctl.finish = at_end && !(sts.held && !drain_char_reg);

    assign s_tready = !flush_reg && ((count_reg != CNT_W'(WIN_DEPTH)) || consume);
    assign accept   = s_tvalid && s_tready;
    assign count_sh = consume ? (count_reg - dec.len) : count_reg;

    always_comb begin
        logic [CNT_W:0] idx;
        for (int i = 0; i < WIN_DEPTH; i++) begin
            idx = (CNT_W+1)'(i) + (consume ? {1'b0, dec.len} : '0);
            win_next[i] = (idx < (CNT_W+1)'(WIN_DEPTH)) ?
                          win_reg[idx[$clog2(WIN_DEPTH)-1:0]] : win_reg[i];
        end
        if (accept) begin
            win_next[count_sh[$clog2(WIN_DEPTH)-1:0]] = s_tdata;
        end
    end

    always_comb begin
        count_next = count_sh + CNT_W'(accept);
        flush_next = flush_reg;
        if (ctl.finish) begin
            flush_next = 1'b0;
        end else if (accept && s_tlast) begin
            flush_next = 1'b1;
        end
    end

    always_comb begin
        drain_char_next = drain_char_reg;
        if (ctl.finish) begin
            drain_char_next = 1'b0;
        end else if (flush_reg && ctl.push) begin
            drain_char_next = 1'b1;
        end
    end

    always_comb begin
        space_pending_next = space_pending_reg;
        if (ctl.finish || ctl.spill) begin
            space_pending_next = 1'b0;
        end else if (step_go && space_first) begin
            space_pending_next = 1'b0;
        end else if (step_go && dec.act == ACT_SPACE) begin
            // only a space after some character can matter
            space_pending_next = space_pending_reg || sts.held;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg         <= '0;
            flush_reg         <= 1'b0;
            space_pending_reg <= 1'b0;
            drain_char_reg    <= 1'b0;
        end else begin
            count_reg         <= count_next;
            flush_reg         <= flush_next;
            space_pending_reg <= space_pending_next;
            drain_char_reg    <= drain_char_next;
        end
        win_reg <= win_next;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(WIN_DEPTH))
        else $error("window count overflow");

    a_last_starts_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> (flush_reg && !s_tready))
        else $error("input not stalled after end of string");

    a_space_needs_char: assert property (@(posedge aclk) disable iff (!aresetn)
        space_pending_reg |-> sts.held)
        else $error("space pending with no preceding character");

endmodule
